/* hdl/crcfr_pkg.sv */
// crcfr_pkg: shared types, codes and the crc-32 lookup table of the frame receiver
`default_nettype none
package crcfr_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned POS_W    = 10;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned REGIDX_W = 2;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_LIM = LEN_W'(MAX_PAYLOAD);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_END  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_CRC  = 2'd3;

    localparam logic [REGIDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_MAX_LENGTH   = 2'd2;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd170;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd187;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RST   = 11'd1024;

    typedef logic [255:0][CRC_W-1:0] t_crc_lut;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
        logic [LEN_W-1:0]  max_length;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] type_byte;
        logic [LEN_W-1:0]  payload_length;
        logic [CRC_W-1:0]  computed_crc;
        logic [CRC_W-1:0]  received_crc;
    } t_result;

    function automatic t_crc_lut gen_crc_lut();
        t_crc_lut tbl;
        logic [CRC_W-1:0] c;
        for (int i = 0; i < 256; i++) begin
            c = {8'(i), 24'h000000};
            for (int k = 0; k < 8; k++) begin
                if (c[CRC_W-1]) begin
                    c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
                end else begin
                    c = {c[CRC_W-2:0], 1'b0};
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam t_crc_lut CRC_LUT = gen_crc_lut();

endpackage
`default_nettype wire

/* hdl/crcfr_ifs.sv */
// crcfr_ifs: valid/ready channel interfaces for received bytes, results and register writes
`default_nettype none
interface crcfr_in_if;
    logic                       valid;
    logic                       ready;
    logic [crcfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [crcfr_pkg::KIND_W-1:0] kind;
    logic [crcfr_pkg::BYTE_W-1:0] payload_byte;
    logic [crcfr_pkg::POS_W-1:0]  byte_position;
    logic [crcfr_pkg::BYTE_W-1:0] type_byte;
    logic [crcfr_pkg::LEN_W-1:0]  payload_length;
    logic [crcfr_pkg::CRC_W-1:0]  computed_crc;
    logic [crcfr_pkg::CRC_W-1:0]  received_crc;

    modport source (output valid, output kind, output payload_byte, output byte_position,
                    output type_byte, output payload_length, output computed_crc,
                    output received_crc, input ready);
    modport sink   (input valid, input kind, input payload_byte, input byte_position,
                    input type_byte, input payload_length, input computed_crc,
                    input received_crc, output ready);
endinterface

interface crcfr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crcfr_pkg::REGIDX_W-1:0] reg_index;
    logic [crcfr_pkg::LEN_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface
`default_nettype wire

/* hdl/crcfr_cfg_regs.sv */
// crcfr_cfg_regs: configuration registers written over the register channel
`default_nettype none
module crcfr_cfg_regs (
    input  wire                i_clk,
    input  wire                i_rst_n,
    crcfr_cfg_if.sink          i_cfg,
    output crcfr_pkg::t_cfg    o_cfg
);
    import crcfr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_START_MARKER: n_cfg.start_marker = i_cfg.wr_data[BYTE_W-1:0];
                REG_END_MARKER:   n_cfg.end_marker   = i_cfg.wr_data[BYTE_W-1:0];
                REG_MAX_LENGTH:   n_cfg.max_length   = i_cfg.wr_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
            r_cfg.max_length   <= MAX_LENGTH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule
`default_nettype wire

/* hdl/crcfr_deframer.sv */
// crcfr_deframer: frame parsing state machine with per-byte table crc update
`default_nettype none
module crcfr_deframer (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  crcfr_pkg::t_cfg                 i_cfg,
    input  wire                             i_accept,
    input  wire [crcfr_pkg::BYTE_W-1:0]     i_byte,
    output logic                            o_res_valid,
    output crcfr_pkg::t_result              o_res
);
    import crcfr_pkg::*;

    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TYPE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN0 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN1 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;
    localparam logic [PHASE_W-1:0] PH_CRC  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_END  = 3'd6;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_type,  n_type;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [CRC_W-1:0]   r_crc,   n_crc;
    logic [CRC_W-1:0]   r_fcrc,  n_fcrc;

    logic [CRC_W-1:0]   crc_step;
    logic [15:0]        full_len;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W-1:0]   count_inc;

    assign crc_step  = {r_crc[CRC_W-9:0], 8'h00} ^ CRC_LUT[r_crc[CRC_W-1:CRC_W-8] ^ i_byte];
    assign full_len  = {i_byte, r_len[BYTE_W-1:0]};
    assign limit     = (i_cfg.max_length > MAX_PAYLOAD_LIM) ? MAX_PAYLOAD_LIM
                                                            : i_cfg.max_length;
    assign count_inc = r_count + LEN_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_count = r_count;
        n_crc   = r_crc;
        n_fcrc  = r_fcrc;

        o_res_valid          = 1'b0;
        o_res                = '0;
        o_res.type_byte      = r_type;
        o_res.payload_length = r_len;

        unique case (r_phase)
            PH_TYPE: begin
                if (i_byte != i_cfg.start_marker) begin
                    n_type  = i_byte;
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_len   = LEN_W'(i_byte);
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_count = '0;
                if (full_len > 16'(limit)) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_len   = full_len[LEN_W-1:0];
                    n_phase = (full_len == 16'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                o_res_valid         = 1'b1;
                o_res.kind          = KIND_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.byte_position = r_count[POS_W-1:0];
                n_crc               = crc_step;
                if (count_inc >= r_len) begin
                    n_count = '0;
                    n_phase = PH_CRC;
                end else begin
                    n_count = count_inc;
                end
            end
            PH_CRC: begin
                n_fcrc  = r_fcrc | (CRC_W'(i_byte) << {r_count[1:0], 3'b000});
                n_count = count_inc;
                if (count_inc >= LEN_W'(4)) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                o_res_valid        = 1'b1;
                o_res.computed_crc = r_crc;
                o_res.received_crc = r_fcrc;
                if (i_byte != i_cfg.end_marker) begin
                    o_res.kind = KIND_BAD_END;
                end else if (r_crc != r_fcrc) begin
                    o_res.kind = KIND_BAD_CRC;
                end else begin
                    o_res.kind = KIND_ACCEPTED;
                end
                n_phase = PH_HUNT;
            end
            default: begin
                if (i_byte == i_cfg.start_marker) begin
                    n_phase = PH_TYPE;
                end
            end
        endcase

        // entering or restarting a frame clears the per-frame context
        if (n_phase == PH_TYPE) begin
            n_type  = '0;
            n_len   = '0;
            n_count = '0;
            n_crc   = CRC_INIT;
            n_fcrc  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_type  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_fcrc  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_fcrc  <= n_fcrc;
        end
    end
endmodule
`default_nettype wire

/* hdl/crcfr_out_reg.sv */
// crcfr_out_reg: result register between the parser and the result channel
`default_nettype none
module crcfr_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire                   i_res_valid,
    input  crcfr_pkg::t_result    i_res,
    output logic                  o_space,
    crcfr_out_if.source           o_res
);
    import crcfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || o_res.ready;

    assign o_res.valid          = r_valid;
    assign o_res.kind           = r_res.kind;
    assign o_res.payload_byte   = r_res.payload_byte;
    assign o_res.byte_position  = r_res.byte_position;
    assign o_res.type_byte      = r_res.type_byte;
    assign o_res.payload_length = r_res.payload_length;
    assign o_res.computed_crc   = r_res.computed_crc;
    assign o_res.received_crc   = r_res.received_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= i_res_valid;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_res_valid) begin
            r_res <= i_res;
        end
    end
endmodule
`default_nettype wire

/* hdl/crc_checked_frame_receiver_unit.sv */
// crc_checked_frame_receiver_unit: top level of the crc-checked serial frame receiver
// One received byte is taken per clock, back to back, whenever the result register is empty
// or its transaction completes in the same cycle; the per-byte cost is one crc-32 table lookup
// and the parser state update, which sit between the parser registers and the result register.
// A payload byte appears on the result channel in the cycle after it is taken, a verdict in the
// cycle after the end byte. Registers take their reset values (start 0xAA, end 0xBB, max length
// 1024) and should be written only while no frame is in progress and no result is waiting.
`default_nettype none
module crc_checked_frame_receiver_unit (
    input  wire           i_clk,
    input  wire           i_rst_n,
    crcfr_in_if.sink      i_rx,
    crcfr_out_if.source   o_res,
    crcfr_cfg_if.sink     i_cfg
);
    import crcfr_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;
    logic    space;
    logic    accept;

    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    crcfr_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    crcfr_deframer u_deframer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crcfr_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_res       (o_res)
    );
endmodule
`default_nettype wire

/* hdl/crcfr_checker.sv */
// crcfr_checker: port-level assertions for the frame receiver, bound to the top level
`default_nettype none
module crcfr_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_rx_valid,
    input wire                           i_rx_ready,
    input wire                           i_res_valid,
    input wire                           i_res_ready,
    input wire [crcfr_pkg::KIND_W-1:0]   i_res_kind,
    input wire [crcfr_pkg::BYTE_W-1:0]   i_res_payload_byte,
    input wire [crcfr_pkg::CRC_W-1:0]    i_res_computed_crc
);
    import crcfr_pkg::*;

    // a held result keeps its contents
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_kind)
            && $stable(i_res_payload_byte) && $stable(i_res_computed_crc))
        else $error("stalled result changed");

    // input is taken whenever the result side can move
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid || i_res_ready |-> i_rx_ready)
        else $error("input stalled without a waiting result");

    // a fresh result always comes from a byte taken in the cycle before
    a_result_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && $past(i_rst_n) && (!$past(i_res_valid) || $past(i_res_ready))
            |-> $past(i_rx_valid && i_rx_ready))
        else $error("result appeared without an input transaction");
endmodule

bind crc_checked_frame_receiver_unit crcfr_checker u_crcfr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rx_valid         (i_rx.valid),
    .i_rx_ready         (i_rx.ready),
    .i_res_valid        (o_res.valid),
    .i_res_ready        (o_res.ready),
    .i_res_kind         (o_res.kind),
    .i_res_payload_byte (o_res.payload_byte),
    .i_res_computed_crc (o_res.computed_crc)
);
`default_nettype wire

/* sim/tb.sv */
// tb: self-checking testbench for the crc-checked frame receiver, with a built-in frame predictor
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned IDLE_PERCENT = 35;
    localparam logic [REGIDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [PHASE_W-1:0] {
        FR_HUNT   = 3'd0,
        FR_TYPE   = 3'd1,
        FR_LEN_LO = 3'd2,
        FR_LEN_HI = 3'd3,
        FR_DATA   = 3'd4,
        FR_CRC    = 3'd5,
        FR_END    = 3'd6
    } t_rx_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   throttle;

    always #2 i_clk = ~i_clk;

    crcfr_in_if  rx_ch();
    crcfr_out_if res_ch();
    crcfr_cfg_if cfg_ch();

    crc_checked_frame_receiver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // receiver state as predicted
    t_cfg             rx_cfg = '{START_MARKER_RST, END_MARKER_RST, MAX_LENGTH_RST};
    t_rx_phase        rx_phase = FR_HUNT;
    logic [BYTE_W-1:0] frame_type = '0;
    logic [15:0]      length_value = '0;
    logic [LEN_W-1:0] byte_count = '0;
    logic [CRC_W-1:0] running_crc = CRC_INIT;
    logic [CRC_W-1:0] frame_crc = '0;

    t_result     frame_results[$];
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;

    function automatic logic [CRC_W-1:0] crc_after_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic int unsigned length_limit();
        return (rx_cfg.max_length < MAX_PAYLOAD) ? rx_cfg.max_length : MAX_PAYLOAD;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return 8'h00;
        end else if (pick < 20) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic track_rx_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        case (rx_phase)
            FR_TYPE: begin
                if (b != rx_cfg.start_marker) begin
                    frame_type = b;
                    rx_phase = FR_LEN_LO;
                end
            end
            FR_LEN_LO: begin
                length_value = {8'h00, b};
                rx_phase = FR_LEN_HI;
            end
            FR_LEN_HI: begin
                length_value[15:8] = b;
                byte_count = '0;
                if (32'(length_value) > length_limit()) begin
                    rx_phase = FR_HUNT;
                end else if (length_value == 16'd0) begin
                    rx_phase = FR_CRC;
                end else begin
                    rx_phase = FR_DATA;
                end
            end
            FR_DATA: begin
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.byte_position = byte_count[POS_W-1:0];
                r.type_byte = frame_type;
                r.payload_length = length_value[LEN_W-1:0];
                frame_results.push_back(r);
                running_crc = crc_after_byte(running_crc, b);
                byte_count = byte_count + 1'b1;
                if (16'(byte_count) >= length_value) begin
                    byte_count = '0;
                    rx_phase = FR_CRC;
                end
            end
            FR_CRC: begin
                frame_crc = frame_crc | (32'(b) << (8 * byte_count[1:0]));
                byte_count = byte_count + 1'b1;
                if (byte_count >= 11'd4) begin
                    rx_phase = FR_END;
                end
            end
            FR_END: begin
                if (b != rx_cfg.end_marker) begin
                    r.kind = KIND_BAD_END;
                end else if (running_crc != frame_crc) begin
                    r.kind = KIND_BAD_CRC;
                end else begin
                    r.kind = KIND_ACCEPTED;
                end
                r.type_byte = frame_type;
                r.payload_length = length_value[LEN_W-1:0];
                r.computed_crc = running_crc;
                r.received_crc = frame_crc;
                frame_results.push_back(r);
                rx_phase = FR_HUNT;
            end
            default: begin
                if (b == rx_cfg.start_marker) begin
                    rx_phase = FR_TYPE;
                end
            end
        endcase
        if (rx_phase == FR_TYPE) begin
            frame_type = '0;
            length_value = '0;
            byte_count = '0;
            running_crc = CRC_INIT;
            frame_crc = '0;
        end
    endtask

    // driving tasks start and end at a falling edge with valid low
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (throttle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge i_clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        track_rx_byte(b);
        bytes_sent++;
        @(negedge i_clk);
        rx_ch.valid = 1'b0;
    endtask

    task automatic write_register(input logic [REGIDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data = data;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_START_MARKER: rx_cfg.start_marker = data[BYTE_W-1:0];
            REG_END_MARKER:   rx_cfg.end_marker = data[BYTE_W-1:0];
            REG_MAX_LENGTH:   rx_cfg.max_length = data;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (frame_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // finish any partial frame, then let the block go idle
    task automatic quiesce();
        logic [BYTE_W-1:0] filler;
        while (rx_phase != FR_HUNT) begin
            filler = rand_byte();
            while (filler == rx_cfg.start_marker) begin
                filler = rand_byte();
            end
            send_byte(filler);
        end
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // stops after the n_data data bytes when n_data differs from len_field
    task automatic send_frame(input int unsigned len_field, input int unsigned n_data,
                              input bit restart, input bit bad_crc, input bit bad_tail,
                              input bit pause);
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] tail;
        logic [CRC_W-1:0]  crc;
        crc = CRC_INIT;
        ftype = rand_byte();
        while (ftype == rx_cfg.start_marker) begin
            ftype = rand_byte();
        end
        send_byte(rx_cfg.start_marker);
        if (restart) begin
            send_byte(rx_cfg.start_marker);
        end
        send_byte(ftype);
        send_byte(len_field[7:0]);
        send_byte(len_field[15:8]);
        for (int unsigned i = 0; i < n_data; i++) begin
            if (pause && i == n_data / 2) begin
                wait_results_drained();
            end
            b = rand_byte();
            crc = crc_after_byte(crc, b);
            send_byte(b);
        end
        if (n_data != len_field) begin
            return;
        end
        if (bad_crc) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        end
        for (int i = 0; i < 4; i++) begin
            send_byte(crc[8*i +: 8]);
        end
        tail = rx_cfg.end_marker;
        if (bad_tail) begin
            while (tail == rx_cfg.end_marker) begin
                tail = rand_byte();
            end
        end
        send_byte(tail);
    endtask

    task automatic test_default_frames();
        send_byte(8'h00);
        send_frame(0, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(1, 1, 1'b0, 1'b0, 1'b1, 1'b0);
        send_frame(2, 2, 1'b0, 1'b1, 1'b0, 1'b0);
        send_frame(16'hFFFF, 0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_register_extremes();
        quiesce();
        write_register(REG_START_MARKER, 11'h700);
        write_register(REG_END_MARKER, 11'h0FF);
        write_register(REG_MAX_LENGTH, 11'd0);
        send_frame(0, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        quiesce();
        write_register(REG_START_MARKER, 11'h0FF);
        write_register(REG_END_MARKER, 11'h600);
        write_register(REG_MAX_LENGTH, 11'h7FF);
        send_frame(3, 3, 1'b1, 1'b0, 1'b0, 1'b0);
        send_frame(MAX_PAYLOAD + 1, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        quiesce();
        write_register(REG_UNUSED, 11'h555);
        send_frame(1, 1, 1'b0, 1'b0, 1'b0, 1'b0);
        quiesce();
        write_register(REG_START_MARKER, LEN_W'(START_MARKER_RST));
        write_register(REG_END_MARKER, LEN_W'(END_MARKER_RST));
        write_register(REG_MAX_LENGTH, MAX_LENGTH_RST);
    endtask

    task automatic test_sender_pause();
        send_frame(6, 6, 1'b0, 1'b0, 1'b0, 1'b1);
        wait_results_drained();
        send_frame(2, 2, 1'b0, 1'b1, 1'b0, 1'b0);
    endtask

    // a frame exactly at the configured limit, then one byte over it
    task automatic test_length_limit();
        quiesce();
        write_register(REG_MAX_LENGTH, 11'd40);
        send_frame(40, 40, 1'b0, 1'b0, 1'b0, 1'b0);
        send_frame(41, 0, 1'b0, 1'b0, 1'b0, 1'b0);
        quiesce();
        write_register(REG_MAX_LENGTH, MAX_LENGTH_RST);
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned lim;
        int unsigned len;
        int unsigned pick;
        logic [BYTE_W-1:0] marker;
        for (int ph = 0; ph < 4; ph++) begin
            quiesce();
            if (ph == 1) begin
                write_register(REG_START_MARKER, LEN_W'($urandom_range(0, 2047)));
                write_register(REG_END_MARKER, LEN_W'($urandom_range(0, 2047)));
                write_register(REG_MAX_LENGTH, LEN_W'($urandom_range(8, 2047)));
            end else if (ph == 2) begin
                marker = BYTE_W'($urandom_range(0, 255));
                write_register(REG_START_MARKER, {3'b000, marker});
                write_register(REG_END_MARKER, {3'b111, marker});
                write_register(REG_MAX_LENGTH, 11'h7FF);
                throttle = 1'b0;
            end else if (ph == 3) begin
                throttle = 1'b1;
                write_register(REG_START_MARKER, LEN_W'($urandom_range(0, 255)));
                write_register(REG_END_MARKER, LEN_W'($urandom_range(0, 255)));
                write_register(REG_MAX_LENGTH, LEN_W'($urandom_range(8, MAX_PAYLOAD)));
            end
            goal = bytes_sent + 230;
            while (bytes_sent < goal) begin
                lim = length_limit();
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                       : $urandom_range(9, 48);
                    if (len > lim) begin
                        len = lim;
                    end
                    send_frame(len, len, $urandom_range(0, 9) == 0,
                               $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 15,
                               $urandom_range(0, 49) == 0);
                end else if (pick < 82) begin
                    send_frame($urandom_range(lim + 1, 65535), 0, 1'b0, 1'b0, 1'b0, 1'b0);
                end else if (pick < 90) begin
                    len = $urandom_range(2, 8);
                    send_frame(len, $urandom_range(0, len - 1), 1'b0, 1'b0, 1'b0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(($urandom_range(0, 4) == 0) ? rx_cfg.start_marker
                                                              : rand_byte());
                    end
                end
            end
        end
        throttle = 1'b1;
    endtask

    always @(negedge i_clk) begin
        res_ch.ready = !throttle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    task automatic check_field(input string name, input logic [CRC_W-1:0] want,
                               input logic [CRC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (frame_results.size() == 0) begin
                $error("unexpected result transaction, kind %0d", res_ch.kind);
                mismatch_count++;
            end else begin
                want = frame_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(res_ch.kind));
                check_field("payload_byte", 32'(want.payload_byte), 32'(res_ch.payload_byte));
                check_field("byte_position", 32'(want.byte_position),
                            32'(res_ch.byte_position));
                check_field("type_byte", 32'(want.type_byte), 32'(res_ch.type_byte));
                check_field("payload_length", 32'(want.payload_length),
                            32'(res_ch.payload_length));
                check_field("computed_crc", want.computed_crc, res_ch.computed_crc);
                check_field("received_crc", want.received_crc, res_ch.received_crc);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned guard;
        i_rst_n = 1'b0;
        throttle = 1'b1;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = REG_START_MARKER;
        cfg_ch.wr_data = '0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_frames();
        test_register_extremes();
        test_sender_pause();
        test_length_limit();
        test_random_traffic();

        guard = 0;
        while (frame_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (frame_results.size() != 0) begin
            $error("%0d expected results never arrived", frame_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/crcfr_pkg.sv
hdl/crcfr_ifs.sv
hdl/crcfr_cfg_regs.sv
hdl/crcfr_deframer.sv
hdl/crcfr_out_reg.sv
hdl/crc_checked_frame_receiver_unit.sv
hdl/crcfr_checker.sv
sim/tb.sv
